@@ design/xml_stream_tokenizer_top_assert.svh @@
// Assertion macros shared by the tokenizer modules.
// Each use expects a signal named clk, and XST_ASSERT also rst_n, in the enclosing module.
`ifndef XML_STREAM_TOKENIZER_TOP_ASSERT_SVH
`define XML_STREAM_TOKENIZER_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define XST_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("xml tokenizer assertion failed");
`define XST_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("xml tokenizer assertion failed");
`else
`define XST_ASSERT(lbl, prop)
`define XST_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

@@ design/xst_pkg.sv @@
package xst_pkg;

    localparam int MAX_RESULTS = 5;
    localparam int RES_CNT_W   = $clog2(MAX_RESULTS + 1);
    localparam int QUEUE_DEPTH = 8;

    typedef enum logic [2:0] {
        EV_NAME  = 3'd0,
        EV_START = 3'd1,
        EV_END   = 3'd2,
        EV_ATTR  = 3'd3,
        EV_VALUE = 3'd4,
        EV_DONE  = 3'd5,
        EV_ERROR = 3'd6
    } event_kind_t;

    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_QM    = 8'h3F;
    localparam logic [7:0] CH_BANG  = 8'h21;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_DQ    = 8'h22;
    localparam logic [7:0] CH_SQ    = 8'h27;
    localparam logic [7:0] CH_AMP   = 8'h26;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_A     = 8'h61;
    localparam logic [7:0] CH_M     = 8'h6D;
    localparam logic [7:0] CH_P     = 8'h70;
    localparam logic [7:0] CASE_BIT = 8'h20;

    typedef struct packed {
        logic       func;
        logic [7:0] byte_in;
    } in_item_t;

    typedef struct packed {
        event_kind_t event_kind;
        logic [7:0]  char_out;
        logic        last;
    } out_item_t;

    // Results of one request, slot 0 first, as handed from parser to queue.
    typedef struct packed {
        logic [RES_CNT_W-1:0]             count;
        out_item_t [MAX_RESULTS-1:0]      slot;
    } step_t;

endpackage

@@ design/xst_parser.sv @@
`include "xml_stream_tokenizer_top_assert.svh"

module xst_parser
    import xst_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     accept,
    input  in_item_t item,
    output step_t    step
);

    typedef enum logic [3:0] {
        ST_WAIT       = 4'd0,
        ST_OPEN       = 4'd1,
        ST_SKIP       = 4'd2,
        ST_NAME       = 4'd3,
        ST_ATTR_SEEK  = 4'd4,
        ST_ATTR_NAME  = 4'd5,
        ST_EQ_SEEK    = 4'd6,
        ST_QUOTE_SEEK = 4'd7,
        ST_DQ_VALUE   = 4'd8,
        ST_SQ_VALUE   = 4'd9,
        ST_CLOSE      = 4'd10
    } pstate_t;

    pstate_t     state_reg, state_next;
    logic        stuck_reg, stuck_next;
    logic [2:0]  hc_reg, hc_next;
    logic [7:0]  hold_reg [4];

    logic        hold_we;
    logic [1:0]  hold_idx;
    logic [7:0]  hold_data;
    logic        do_flush;
    logic [1:0]  n_extra;
    event_kind_t ex0_kind, ex1_kind;
    logic [7:0]  ex0_char;
    logic [7:0]  c;
    logic        blank;
    logic        closing;
    logic [2:0]  fl_cnt;
    logic [2:0]  total;

    function automatic logic pat_hit(input logic [2:0] pos, input logic [7:0] ch);
        logic hit;
        case (pos)
            3'd0:    hit = (ch == CH_AMP);
            3'd1:    hit = ((ch | CASE_BIT) == CH_A);
            3'd2:    hit = ((ch | CASE_BIT) == CH_M);
            3'd3:    hit = ((ch | CASE_BIT) == CH_P);
            default: hit = 1'b0;
        endcase
        return hit;
    endfunction

    assign c     = item.byte_in;
    assign blank = c inside {8'h20, 8'h09, 8'h0D, 8'h0A};

    always_comb
    begin
        state_next = state_reg;
        stuck_next = stuck_reg;
        hc_next    = hc_reg;
        hold_we    = 1'b0;
        hold_idx   = 2'd0;
        hold_data  = c;
        do_flush   = 1'b0;
        n_extra    = 2'd0;
        ex0_kind   = EV_NAME;
        ex0_char   = 8'd0;
        ex1_kind   = EV_NAME;
        closing    = (state_reg == ST_DQ_VALUE && c == CH_DQ) ||
                     (state_reg == ST_SQ_VALUE && c == CH_SQ);

        if (item.func)
        begin
            state_next = ST_WAIT;
            stuck_next = 1'b0;
            hc_next    = 3'd0;
        end
        else if (!stuck_reg)
        begin
            case (state_reg)
                ST_WAIT:
                begin
                    if (c == CH_LT)
                        state_next = ST_OPEN;
                end
                ST_OPEN:
                begin
                    if (c == CH_QM || c == CH_BANG)
                        state_next = ST_SKIP;
                    else if (c == CH_SLASH)
                        state_next = ST_CLOSE;
                    else
                    begin
                        n_extra    = 2'd1;
                        ex0_kind   = EV_NAME;
                        ex0_char   = c;
                        state_next = ST_NAME;
                    end
                end
                ST_SKIP:
                begin
                    if (c == CH_GT)
                        state_next = ST_WAIT;
                end
                ST_NAME:
                begin
                    if (c == CH_SLASH)
                    begin
                        n_extra    = 2'd2;
                        ex0_kind   = EV_START;
                        ex1_kind   = EV_END;
                        state_next = ST_SKIP;
                    end
                    else if (!blank && c != CH_GT)
                    begin
                        n_extra  = 2'd1;
                        ex0_kind = EV_NAME;
                        ex0_char = c;
                    end
                    else
                    begin
                        n_extra    = 2'd1;
                        ex0_kind   = EV_START;
                        state_next = (c == CH_GT) ? ST_WAIT : ST_ATTR_SEEK;
                    end
                end
                ST_ATTR_SEEK:
                begin
                    if (c == CH_GT)
                        state_next = ST_WAIT;
                    else if (c == CH_SLASH)
                    begin
                        n_extra    = 2'd1;
                        ex0_kind   = EV_END;
                        state_next = ST_WAIT;
                    end
                    else if (!blank)
                    begin
                        n_extra    = 2'd1;
                        ex0_kind   = EV_ATTR;
                        ex0_char   = c;
                        state_next = ST_ATTR_NAME;
                    end
                end
                ST_ATTR_NAME:
                begin
                    if (c == CH_GT)
                    begin
                        n_extra    = 2'd1;
                        ex0_kind   = EV_ERROR;
                        stuck_next = 1'b1;
                    end
                    else if (c == CH_EQ)
                        state_next = ST_QUOTE_SEEK;
                    else if (!blank)
                    begin
                        n_extra  = 2'd1;
                        ex0_kind = EV_ATTR;
                        ex0_char = c;
                    end
                    else
                        state_next = ST_EQ_SEEK;
                end
                ST_EQ_SEEK:
                begin
                    if (c == CH_EQ)
                        state_next = ST_QUOTE_SEEK;
                    else if (!blank)
                    begin
                        n_extra    = 2'd1;
                        ex0_kind   = EV_ERROR;
                        stuck_next = 1'b1;
                    end
                end
                ST_QUOTE_SEEK:
                begin
                    if (c == CH_DQ)
                        state_next = ST_DQ_VALUE;
                    else if (c == CH_SQ)
                        state_next = ST_SQ_VALUE;
                    else if (!blank)
                    begin
                        n_extra    = 2'd1;
                        ex0_kind   = EV_ERROR;
                        stuck_next = 1'b1;
                    end
                end
                ST_DQ_VALUE, ST_SQ_VALUE:
                begin
                    if (closing)
                    begin
                        do_flush   = 1'b1;
                        hc_next    = 3'd0;
                        n_extra    = 2'd1;
                        ex0_kind   = EV_DONE;
                        state_next = ST_ATTR_SEEK;
                    end
                    else if (hc_reg >= 3'd4 && c == CH_SEMI)
                    begin
                        // A complete escape collapses to one held ampersand.
                        hold_we   = 1'b1;
                        hold_data = CH_AMP;
                        hc_next   = 3'd1;
                    end
                    else if (hc_reg < 3'd4 && pat_hit(hc_reg, c))
                    begin
                        hold_we  = 1'b1;
                        hold_idx = hc_reg[1:0];
                        hc_next  = hc_reg + 3'd1;
                    end
                    else
                    begin
                        // The match is broken: release what is held first.
                        do_flush = 1'b1;
                        if (c == CH_AMP)
                        begin
                            hold_we = 1'b1;
                            hc_next = 3'd1;
                        end
                        else
                        begin
                            hc_next  = 3'd0;
                            n_extra  = 2'd1;
                            ex0_kind = EV_VALUE;
                            ex0_char = c;
                        end
                    end
                end
                ST_CLOSE:
                begin
                    if (c == CH_GT)
                    begin
                        n_extra    = 2'd1;
                        ex0_kind   = EV_END;
                        state_next = ST_WAIT;
                    end
                end
                default:
                begin
                    state_next = state_reg;
                end
            endcase
        end
    end

    assign fl_cnt = do_flush ? hc_reg : 3'd0;
    assign total  = fl_cnt + {1'b0, n_extra};

    always_comb
    begin
        step.count = RES_CNT_W'(total);
        for (int k = 0; k < MAX_RESULTS; k++)
        begin
            if (3'(k) < fl_cnt)
            begin
                step.slot[k].event_kind = EV_VALUE;
                step.slot[k].char_out   = hold_reg[2'(k)];
            end
            else if (3'(k) == fl_cnt)
            begin
                step.slot[k].event_kind = ex0_kind;
                step.slot[k].char_out   = ex0_char;
            end
            else
            begin
                step.slot[k].event_kind = ex1_kind;
                step.slot[k].char_out   = 8'd0;
            end
            step.slot[k].last = (total != 3'd0) && (3'(k) == total - 3'd1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_WAIT;
            stuck_reg <= 1'b0;
            hc_reg    <= 3'd0;
        end
        else if (accept)
        begin
            state_reg <= state_next;
            stuck_reg <= stuck_next;
            hc_reg    <= hc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && hold_we)
            hold_reg[hold_idx] <= hold_data;
    end

    `XST_ASSERT(a_stuck_silent, (stuck_reg && !item.func) |-> (step.count == RES_CNT_W'(0)))
    `XST_ASSERT(a_restart_idle, (accept && item.func) |=> (state_reg == ST_WAIT && hc_reg == 3'd0 && !stuck_reg))
    `XST_ASSERT(a_hold_bound, hc_reg <= 3'd4)

endmodule

@@ design/xml_stream_tokenizer_top.sv @@
// The results of an accepted request are registered into the result queue.
// Throughput: one request per cycle; a request giving n results drains
// through the eight-entry result queue at one result per cycle while result_stall
// is low, and new requests are held off while more than three results wait in it.
// Reset: rst_n clears parse state, error flag, escape hold count and queue.
`include "xml_stream_tokenizer_top_assert.svh"

module xml_stream_tokenizer_top
    import xst_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      item_valid,
    output logic      item_stall,
    input  in_item_t  item,
    output logic      result_valid,
    input  logic      result_stall,
    output out_item_t result
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CNT_W-1:0] ACCEPT_MAX = CNT_W'(QUEUE_DEPTH - MAX_RESULTS);

    step_t            step;
    logic             accept;
    logic             pop;
    logic [RES_CNT_W-1:0] push_n;

    out_item_t        q_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    xst_parser u_parser (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .item   (item),
        .step   (step)
    );

    // Room for the largest burst of one request must be free before it is taken.
    assign item_stall   = count_reg > ACCEPT_MAX;
    assign accept       = item_valid && !item_stall;
    assign result_valid = count_reg != '0;
    assign result       = q_reg[rd_ptr_reg];
    assign pop          = result_valid && !result_stall;
    assign push_n       = accept ? step.count : '0;

    assign wr_ptr_next = wr_ptr_reg + PTR_W'(push_n);
    assign rd_ptr_next = rd_ptr_reg + PTR_W'(pop);
    assign count_next  = count_reg + CNT_W'(push_n) - CNT_W'(pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < MAX_RESULTS; k++)
        begin
            if (RES_CNT_W'(k) < push_n)
                q_reg[wr_ptr_reg + PTR_W'(k)] <= step.slot[k];
        end
    end

    `XST_ASSERT(a_count_bound, count_reg <= CNT_W'(QUEUE_DEPTH))
    `XST_ASSERT(a_push_visible, (accept && step.count != RES_CNT_W'(0)) |=> result_valid)
    `XST_ASSERT(a_drain_one, (pop && !accept) |=> (count_reg == $past(count_reg) - CNT_W'(1)))

endmodule
